// File: design/erfcr_pkg.sv
// Shared constants and pipeline payload types for the erfc/erf pipeline.
package erfcr_pkg;

    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS = 4;
    localparam int HORNER_STAGES = 9;
    localparam int EXP_TERMS = 12;
    localparam int EXP_STAGES = 3 * EXP_TERMS;

    localparam logic [63:0] Q30_HALF = 64'd536870912;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [30:0] LN2_Q30 = 31'd744261118;
    localparam logic [16:0] LN2_RECIP = 17'd94548;
    localparam logic [17:0] ONE_Q16 = 18'd65536;
    localparam logic [17:0] TWO_Q16 = 18'd131072;
    localparam logic [15:0] DIV_START_REM = 16'd2048;

    // Polynomial coefficients in Q.30, constant term first.
    localparam logic signed [34:0] POLY_Q30 [10] = '{
        -35'sd1358833410,
         35'sd1073767250,
         35'sd401678183,
         35'sd103921222,
        -35'sd200025281,
         35'sd299432310,
        -35'sd1218915992,
         35'sd1598281745,
        -35'sd882779235,
         35'sd183473240
    };

    // Scaled reciprocals floor(2^36 / n) for the series denominators.
    localparam logic [36:0] EXP_RECIP [13] = '{
        37'd0,
        37'((64'd1 << 36) / 64'd1),
        37'((64'd1 << 36) / 64'd2),
        37'((64'd1 << 36) / 64'd3),
        37'((64'd1 << 36) / 64'd4),
        37'((64'd1 << 36) / 64'd5),
        37'((64'd1 << 36) / 64'd6),
        37'((64'd1 << 36) / 64'd7),
        37'((64'd1 << 36) / 64'd8),
        37'((64'd1 << 36) / 64'd9),
        37'((64'd1 << 36) / 64'd10),
        37'((64'd1 << 36) / 64'd11),
        37'((64'd1 << 36) / 64'd12)
    };

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [15:0] z;
        logic [15:0] d;
        logic [15:0] rem;
        logic [31:0] quo;
    } div_t;

    typedef struct packed {
        logic               neg;
        logic               zero;
        logic [15:0]        z;
        logic [30:0]        t;
        logic signed [34:0] p;
    } hrn_t;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [30:0] t;
        logic [36:0] m;
        logic [7:0]  qe;
        logic [30:0] rem;
        logic [7:0]  k;
        logic [29:0] r;
    } kst_t;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [30:0] t;
        logic [7:0]  k;
        logic [29:0] r;
        logic [31:0] acc;
        logic [31:0] y;
        logic [31:0] q;
    } exs_t;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [7:0]  k;
        logic [62:0] prod;
    } fin_t;

endpackage

// File: design/erfc_rational_exp_approx_top.sv
// Fully pipelined erfc(x) and erf(x) of a Q4.12 argument, both results in Q2.16.
// Throughput: one request per cycle; the 32-bit reciprocal divider, the nine Horner
// steps and the twelve-term exponential series each run as their own register stages.
// A stall on the master side freezes the whole pipeline in place.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is not reset.
module erfc_rational_exp_approx_top
    import erfcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] argument
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [17:0] erfc_value, [35:18] erf_value, [39:36] zero
);

    logic adv;

    // Stage registers and valid bits.
    div_t        div_reg   [DIV_STAGES + 1];
    logic        div_v_reg [DIV_STAGES + 1];
    hrn_t        hrn_reg   [HORNER_STAGES + 1];
    logic        hrn_v_reg [HORNER_STAGES + 1];
    kst_t        kst_reg   [4];
    logic        kst_v_reg [4];
    exs_t        exs_reg   [EXP_STAGES];
    logic        exs_v_reg [EXP_STAGES];
    fin_t        fin_reg;
    logic        fin_v_reg;
    logic [39:0] out_data_reg;
    logic        out_valid_reg;

    // The pipeline moves whenever the output register is free or being drained.
    assign adv = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // Input stage: take the magnitude and set up the divider for t = 8192 / (8192 + z).
    always_ff @(posedge aclk) begin
        logic [15:0] z_in;
        z_in = s_tdata[15] ? 16'(-s_tdata) : s_tdata;
        if (!aresetn) begin
            div_v_reg[0] <= 1'b0;
        end else if (adv) begin
            div_v_reg[0] <= s_tvalid;
        end
        if (adv) begin
            div_reg[0].neg  <= s_tdata[15];
            div_reg[0].zero <= (s_tdata == 16'd0);
            div_reg[0].z    <= z_in;
            div_reg[0].d    <= z_in + 16'd8192;
            div_reg[0].rem  <= DIV_START_REM;
            div_reg[0].quo  <= 32'd0;
        end
    end

    // Restoring divider of (2^43 + d/2) by d, four quotient bits per stage.
    for (genvar gs = 0; gs < DIV_STAGES; gs++) begin : g_div
        div_t div_next;
        always_comb begin
            logic [16:0] rem_w;
            logic [4:0]  bit_idx;
            logic [31:0] num_low;
            div_next = div_reg[gs];
            num_low = {17'd0, div_reg[gs].d[15:1]};
            for (int b = 0; b < DIV_BITS; b++) begin
                bit_idx = 5'(31 - (gs * DIV_BITS + b));
                rem_w = {div_next.rem, num_low[bit_idx]};
                div_next.quo = {div_next.quo[30:0], 1'b0};
                if (rem_w >= {1'b0, div_next.d}) begin
                    rem_w = rem_w - {1'b0, div_next.d};
                    div_next.quo[0] = 1'b1;
                end
                div_next.rem = rem_w[15:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_v_reg[gs + 1] <= 1'b0;
            end else if (adv) begin
                div_v_reg[gs + 1] <= div_v_reg[gs];
            end
            if (adv) begin
                div_reg[gs + 1] <= div_next;
            end
        end
    end

    // Horner seed: the highest coefficient.
    always_comb begin
        hrn_reg[0].neg  = div_reg[DIV_STAGES].neg;
        hrn_reg[0].zero = div_reg[DIV_STAGES].zero;
        hrn_reg[0].z    = div_reg[DIV_STAGES].z;
        hrn_reg[0].t    = div_reg[DIV_STAGES].quo[30:0];
        hrn_reg[0].p    = POLY_Q30[9];
        hrn_v_reg[0]    = div_v_reg[DIV_STAGES];
    end

    // One Horner step per stage: p = c + t * p, rounded half away from zero.
    for (genvar gh = 0; gh < HORNER_STAGES; gh++) begin : g_hrn
        hrn_t hrn_next;
        always_comb begin
            logic [33:0] mag;
            logic [65:0] prod;
            logic [35:0] rr;
            logic signed [34:0] term;
            mag  = hrn_reg[gh].p[34] ? 34'(-hrn_reg[gh].p) : hrn_reg[gh].p[33:0];
            prod = {32'd0, mag} * {35'd0, hrn_reg[gh].t} + {2'd0, Q30_HALF};
            rr   = prod[65:30];
            term = hrn_reg[gh].p[34] ? -$signed(rr[34:0]) : $signed(rr[34:0]);
            hrn_next   = hrn_reg[gh];
            hrn_next.p = POLY_Q30[8 - gh] + term;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hrn_v_reg[gh + 1] <= 1'b0;
            end else if (adv) begin
                hrn_v_reg[gh + 1] <= hrn_v_reg[gh];
            end
            if (adv) begin
                hrn_reg[gh + 1] <= hrn_next;
            end
        end
    end

    // Exponent stage: e = p - 64 z^2, limited to 0, kept as its negation m.
    always_ff @(posedge aclk) begin
        logic [31:0] zz;
        logic signed [38:0] e;
        kst_t kst_w;
        zz = hrn_reg[HORNER_STAGES].z * hrn_reg[HORNER_STAGES].z;
        e  = 39'(hrn_reg[HORNER_STAGES].p) - $signed({1'b0, zz, 6'd0});
        kst_w      = '0;
        kst_w.neg  = hrn_reg[HORNER_STAGES].neg;
        kst_w.zero = hrn_reg[HORNER_STAGES].zero;
        kst_w.t    = hrn_reg[HORNER_STAGES].t;
        kst_w.m    = (e > 39'sd0) ? 37'd0 : 37'(-e);
        if (!aresetn) begin
            kst_v_reg[0] <= 1'b0;
        end else if (adv) begin
            kst_v_reg[0] <= hrn_v_reg[HORNER_STAGES];
        end
        if (adv) begin
            kst_reg[0] <= kst_w;
        end
    end

    // Range reduction, step one: quotient estimate by reciprocal multiply.
    always_ff @(posedge aclk) begin
        logic [37:0] est;
        kst_t kst_w;
        est = {17'd0, kst_reg[0].m[36:16]} * {21'd0, LN2_RECIP};
        kst_w    = kst_reg[0];
        kst_w.qe = est[37:30];
        if (!aresetn) begin
            kst_v_reg[1] <= 1'b0;
        end else if (adv) begin
            kst_v_reg[1] <= kst_v_reg[0];
        end
        if (adv) begin
            kst_reg[1] <= kst_w;
        end
    end

    // Range reduction, step two: remainder and one correction gives floor(m / ln2).
    always_ff @(posedge aclk) begin
        logic [38:0] rem_w;
        logic [7:0]  q_fix;
        kst_t kst_w;
        rem_w = {2'd0, kst_reg[1].m} - {23'd0, kst_reg[1].qe} * {8'd0, LN2_Q30};
        q_fix = kst_reg[1].qe;
        if (rem_w >= {8'd0, LN2_Q30}) begin
            rem_w = rem_w - {8'd0, LN2_Q30};
            q_fix = q_fix + 8'd1;
        end
        kst_w     = kst_reg[1];
        kst_w.qe  = q_fix;
        kst_w.rem = rem_w[30:0];
        if (!aresetn) begin
            kst_v_reg[2] <= 1'b0;
        end else if (adv) begin
            kst_v_reg[2] <= kst_v_reg[1];
        end
        if (adv) begin
            kst_reg[2] <= kst_w;
        end
    end

    // Range reduction, step three: k = ceil(m / ln2) and r = k ln2 - m.
    always_ff @(posedge aclk) begin
        logic [30:0] r_w;
        kst_t kst_w;
        r_w = LN2_Q30 - kst_reg[2].rem;
        kst_w = kst_reg[2];
        if (kst_reg[2].rem == 31'd0) begin
            kst_w.k = kst_reg[2].qe;
            kst_w.r = 30'd0;
        end else begin
            kst_w.k = kst_reg[2].qe + 8'd1;
            kst_w.r = r_w[29:0];
        end
        if (!aresetn) begin
            kst_v_reg[3] <= 1'b0;
        end else if (adv) begin
            kst_v_reg[3] <= kst_v_reg[2];
        end
        if (adv) begin
            kst_reg[3] <= kst_w;
        end
    end

    // Exponential series: three stages per term (product, reciprocal, correction).
    for (genvar gx = 0; gx < EXP_STAGES; gx++) begin : g_exp
        localparam int TERM_N = EXP_TERMS - gx / 3;
        localparam int PHASE = gx % 3;
        exs_t exs_prev;
        logic exs_prev_v;
        exs_t exs_next;

        if (gx == 0) begin : g_first
            always_comb begin
                exs_prev      = '0;
                exs_prev.neg  = kst_reg[3].neg;
                exs_prev.zero = kst_reg[3].zero;
                exs_prev.t    = kst_reg[3].t;
                exs_prev.k    = kst_reg[3].k;
                exs_prev.r    = kst_reg[3].r;
                exs_prev.acc  = Q30_ONE;
                exs_prev_v    = kst_v_reg[3];
            end
        end else begin : g_rest
            assign exs_prev = exs_reg[gx - 1];
            assign exs_prev_v = exs_v_reg[gx - 1];
        end

        if (PHASE == 0) begin : g_mul
            // y = floor((acc r + n 2^29) / 2^30).
            always_comb begin
                logic [63:0] prod;
                prod = {32'd0, exs_prev.acc} * {34'd0, exs_prev.r}
                     + (64'(TERM_N) << 29);
                exs_next   = exs_prev;
                exs_next.y = prod[61:30];
            end
        end else if (PHASE == 1) begin : g_rcp
            // Quotient estimate of y / n, low by at most one.
            always_comb begin
                logic [68:0] prod;
                prod = {37'd0, exs_prev.y} * {32'd0, EXP_RECIP[TERM_N]};
                exs_next   = exs_prev;
                exs_next.q = prod[67:36];
            end
        end else begin : g_fix
            // Correct the quotient and close the Horner step.
            always_comb begin
                logic [35:0] rem_w;
                logic [31:0] q_w;
                rem_w = {4'd0, exs_prev.y} - {4'd0, exs_prev.q} * 36'(TERM_N);
                q_w   = exs_prev.q;
                if (rem_w >= 36'(TERM_N)) begin
                    q_w = q_w + 32'd1;
                end
                exs_next     = exs_prev;
                exs_next.acc = Q30_ONE + q_w;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                exs_v_reg[gx] <= 1'b0;
            end else if (adv) begin
                exs_v_reg[gx] <= exs_prev_v;
            end
            if (adv) begin
                exs_reg[gx] <= exs_next;
            end
        end
    end

    // Scale by t before the final shift.
    always_ff @(posedge aclk) begin
        logic [62:0] prod;
        prod = {32'd0, exs_reg[EXP_STAGES - 1].t} * {31'd0, exs_reg[EXP_STAGES - 1].acc};
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (adv) begin
            fin_v_reg <= exs_v_reg[EXP_STAGES - 1];
        end
        if (adv) begin
            fin_reg.neg  <= exs_reg[EXP_STAGES - 1].neg;
            fin_reg.zero <= exs_reg[EXP_STAGES - 1].zero;
            fin_reg.k    <= exs_reg[EXP_STAGES - 1].k;
            fin_reg.prod <= prod;
        end
    end

    // Output register: rounding shift by 44 + k, saturation, sign fold and erf.
    always_ff @(posedge aclk) begin
        logic [7:0]  sh;
        logic [63:0] sum;
        logic [63:0] v;
        logic [17:0] v_sat;
        logic [17:0] erfc_w;
        logic [17:0] erf_w;
        sh  = 8'd44 + fin_reg.k;
        sum = {1'b0, fin_reg.prod} + (64'd1 << (sh - 8'd1));
        if (fin_reg.k >= 8'd20) begin
            v = 64'd0;
        end else begin
            v = sum >> sh;
        end
        v_sat = (v > 64'(ONE_Q16)) ? ONE_Q16 : v[17:0];
        if (fin_reg.zero) begin
            erfc_w = ONE_Q16;
        end else if (fin_reg.neg) begin
            erfc_w = TWO_Q16 - v_sat;
        end else begin
            erfc_w = v_sat;
        end
        erf_w = ONE_Q16 - erfc_w;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= fin_v_reg;
        end
        if (adv) begin
            out_data_reg <= {4'd0, erf_w, erfc_w};
        end
    end

endmodule
